// ===== rtl/sprite_xor_framebuffer_assert.svh =====
// Assertion macros for the sprite XOR framebuffer.
// Used by the port checker; depends on nothing else.
`ifndef SPRITE_XOR_FRAMEBUFFER_ASSERT_SVH
`define SPRITE_XOR_FRAMEBUFFER_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SXF_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sprite_xor_framebuffer: assertion failed");

// Concurrent assertion on clk_i and rst_ni.
`define SXF_ASSERT(name, prop) \
  `SXF_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

// ===== rtl/sxf_pkg.sv =====
// Shared types and constants of the sprite XOR framebuffer.
// No dependencies; imported by the top level, sxf_ctrl and sxf_datapath.
`default_nettype none

package sxf_pkg;

  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 32;
  localparam int XW             = $clog2(DISPLAY_WIDTH);
  localparam int YW             = $clog2(DISPLAY_HEIGHT);
  localparam int SPRITE_BITS    = 8;
  localparam logic [3:0] ROW_INVALID = 4'd15;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DRAW  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ROW   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    op_e                    op;
    logic [7:0]             x_pos;
    logic [7:0]             y_pos;
    logic                   pixel_in;
    logic [SPRITE_BITS-1:0] sprite_byte;
    logic [3:0]             row_index;
    logic                   last_row;
  } item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sprite_xor_framebuffer.sv =====
// Top level of the one-bit sprite XOR framebuffer.
// Depends on sxf_pkg, sxf_ctrl and sxf_datapath.
//
// Channel | Direction | Carries
// s_axis  | in        | operation, pixel coordinates, pixel value, sprite row
// m_axis  | out       | status, pixel read value, collision flag, sprite done
//
// Each item is handled in turn: the frame row is read from memory, then updated.
// The single-port frame memory read-modify-write sets this order.
// Clear zeroes a row valid vector, and reset does the same.
// A result waiting in the output register holds the next item in its update cycle,
// and the input stays not ready until that result is taken.
`default_nettype none

module sprite_xor_framebuffer
  import sxf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] x_pos, [15:8] y_pos, [16] pixel_in, [24:17] sprite_byte, [28:25] row_index
  input  wire  [31:0] s_axis_tdata,
  // [1:0] operation
  input  wire  [1:0]  s_axis_tuser,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [0] pixel_out, [1] collision, [7:2] zero
  output logic [7:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  cmd_t    cmd;
  item_t   item;
  status_e status;
  logic    pixel_out, collision;

  assign item.op          = op_e'(s_axis_tuser);
  assign item.x_pos       = s_axis_tdata[7:0];
  assign item.y_pos       = s_axis_tdata[15:8];
  assign item.pixel_in    = s_axis_tdata[16];
  assign item.sprite_byte = s_axis_tdata[24:17];
  assign item.row_index   = s_axis_tdata[28:25];
  assign item.last_row    = s_axis_tlast;

  sxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sxf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_i        (item),
    .status_o      (status),
    .pixel_out_o   (pixel_out),
    .collision_o   (collision),
    .sprite_done_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, collision, pixel_out};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

// ===== rtl/sxf_ctrl.sv =====
// Controller of the sprite XOR framebuffer: item sequencing and output slot.
// Depends on sxf_pkg; drives the command struct of sxf_datapath.
`default_nettype none

module sxf_ctrl
  import sxf_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign cmd_o.capture = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit  = (state_q == S_EXEC) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sxf_datapath.sv =====
// Datapath of the sprite XOR framebuffer: frame memory, row update, result registers.
// Depends on sxf_pkg; sequenced by sxf_ctrl through the command struct.
`default_nettype none

module sxf_datapath
  import sxf_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cmd_t       cmd_i,
  input  item_t      item_i,
  output status_e    status_o,
  output logic       pixel_out_o,
  output logic       collision_o,
  output logic       sprite_done_o
);

  localparam int WIDE = DISPLAY_WIDTH + SPRITE_BITS;

  logic [DISPLAY_WIDTH-1:0]  mem [DISPLAY_HEIGHT];
  logic [DISPLAY_HEIGHT-1:0] row_vld_q;

  item_t                    item_q;
  logic [YW-1:0]            addr_q;
  logic [DISPLAY_WIDTH-1:0] rd_row_q;
  logic                     rd_vld_q;
  logic                     coll_q;

  status_e status_q;
  logic    pixel_q, coll_out_q, done_q;

  logic [8:0]               ty_in, ty;
  logic [YW-1:0]            raddr;
  logic [XW-1:0]            xi;
  logic [DISPLAY_WIDTH-1:0] cur_row, set_row, mask, wr_data;
  logic [WIDE-1:0]          spr_wide;
  logic [SPRITE_BITS-1:0]   spr_rev;
  logic                     coord_ok, ty_ok, hit, flag, wr_en, draw_ok;
  status_e                  status_d;

  assign ty_in = (item_i.op == OP_DRAW) ? ({1'b0, item_i.y_pos} + {5'b0, item_i.row_index})
                                        : {1'b0, item_i.y_pos};
  assign raddr = ty_in[YW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q   <= item_i;
      addr_q   <= raddr;
      rd_row_q <= mem[raddr];
      rd_vld_q <= row_vld_q[raddr];
    end
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
  end

  assign coord_ok = (item_q.x_pos < 8'(DISPLAY_WIDTH)) && (item_q.y_pos < 8'(DISPLAY_HEIGHT));
  assign ty       = {1'b0, item_q.y_pos} + {5'b0, item_q.row_index};
  assign ty_ok    = ty < 9'(DISPLAY_HEIGHT);
  assign xi       = item_q.x_pos[XW-1:0];
  assign cur_row  = rd_vld_q ? rd_row_q : '0;

  // The sprite's leftmost pixel is its MSB; columns past the edge shift out.
  always_comb begin
    for (int j = 0; j < SPRITE_BITS; j++) begin
      spr_rev[j] = item_q.sprite_byte[SPRITE_BITS-1-j];
    end
  end

  assign spr_wide = {{DISPLAY_WIDTH{1'b0}}, spr_rev} << xi;
  assign mask     = spr_wide[DISPLAY_WIDTH-1:0];
  assign hit      = |(cur_row & mask);
  assign flag     = ((item_q.row_index == 4'd0) ? 1'b0 : coll_q) | (ty_ok & hit);

  always_comb begin
    set_row     = cur_row;
    set_row[xi] = item_q.pixel_in;
  end

  always_comb begin
    status_d = ST_OK;
    unique case (item_q.op)
      OP_CLEAR: status_d = ST_OK;
      OP_WRITE, OP_READ: begin
        if (!coord_ok) status_d = ST_RANGE;
      end
      OP_DRAW: begin
        priority if (!coord_ok) status_d = ST_RANGE;
        else if (item_q.row_index == ROW_INVALID) status_d = ST_ROW;
        else status_d = ST_OK;
      end
      default: status_d = ST_OK;
    endcase
  end

  assign draw_ok = (item_q.op == OP_DRAW) && (status_d == ST_OK);
  assign wr_en   = cmd_i.commit &&
                   (((item_q.op == OP_WRITE) && coord_ok) || (draw_ok && ty_ok));
  assign wr_data = (item_q.op == OP_DRAW) ? (cur_row ^ mask) : set_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      coll_q    <= 1'b0;
    end else if (cmd_i.commit) begin
      if (item_q.op == OP_CLEAR) begin
        row_vld_q <= '0;
      end else if (wr_en) begin
        row_vld_q[addr_q] <= 1'b1;
      end
      if (draw_ok) begin
        coll_q <= flag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= status_d;
      pixel_q    <= (item_q.op == OP_READ) && coord_ok && cur_row[xi];
      coll_out_q <= draw_ok && flag;
      done_q     <= (item_q.op == OP_DRAW) && item_q.last_row;
    end
  end

  assign status_o      = status_q;
  assign pixel_out_o   = pixel_q;
  assign collision_o   = coll_out_q;
  assign sprite_done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/sxf_checker.sv =====
// Port checker of the sprite XOR framebuffer, bound to the top level.
// Depends on sprite_xor_framebuffer_assert.svh.
`default_nettype none

`include "sprite_xor_framebuffer_assert.svh"

module sxf_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  `SXF_ASSERT(busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `SXF_ASSERT(status_code_known, m_axis_tvalid |-> (m_axis_tuser != 2'd3))
  `SXF_ASSERT(read_draw_exclusive, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
  `SXF_ASSERT_CLK(out_valid_held, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)

endmodule

bind sprite_xor_framebuffer sxf_checker u_sxf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
